FILE: hdl/short_cycle_lockout_guard_defines.svh
// Assertion macros shared by the short-cycle lockout guard RTL.
`ifndef SHORT_CYCLE_LOCKOUT_GUARD_DEFINES_SVH
`define SHORT_CYCLE_LOCKOUT_GUARD_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SCSLG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SCSLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/scslg_pkg.sv
// Shared types, widths and constants for the short-cycle lockout guard.
package scslg_pkg;

    // Default depth of the stop-time history
    localparam int STOP_HISTORY = 8;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int TPM_W      = 16;
    localparam int MIN_W      = 10;
    localparam int LIM_W      = 4;
    localparam int LOCK_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(TIME_W + 1);

    // Value an unwritten stop-time entry reads as
    localparam logic [TIME_W-1:0] STOP_RESET_VALUE = 32'h7FFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_WINDOW_MINUTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_WINDOW_MINUTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_COUNT_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_COUNT_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_MINUTES     = 3'd5;

    // Configuration reset values
    localparam logic [TPM_W-1:0] TPM_RESET        = 16'd60;
    localparam logic [MIN_W-1:0] SMALL_WIN_RESET  = 10'd10;
    localparam logic [MIN_W-1:0] LARGE_WIN_RESET  = 10'd60;
    localparam logic [LIM_W-1:0] SMALL_LIM_RESET  = 4'd2;
    localparam logic [LIM_W-1:0] LARGE_LIM_RESET  = 4'd4;
    localparam logic [MIN_W-1:0] RECOVERY_RESET   = 10'd15;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TPM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hdl/scslg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scslg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/scslg_div.sv
// Restoring divider, one quotient bit per cycle; divide by zero gives all ones.
module scslg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  scslg_pkg::div_req_t req,
    output scslg_pkg::div_rsp_t rsp
);

    localparam int TW = scslg_pkg::TIME_W;
    localparam int DW = scslg_pkg::TPM_W;
    localparam int CW = scslg_pkg::DIV_CNT_W;

    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [TW-1:0] quo_reg, quo_next;
    logic [DW-1:0] divisor_reg, divisor_next;

    logic [DW:0]   rem_shift;
    logic [DW:0]   trial;
    logic          fits;

    // One step: shift in the next dividend bit, subtract when it fits
    assign rem_shift = {rem_reg, quo_reg[TW-1]};
    assign trial     = rem_shift - {1'b0, divisor_reg};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            count_next   = CW'(TW);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
            rem_next   = fits ? trial[DW-1:0] : rem_shift[DW-1:0];
            quo_next   = {quo_reg[TW-2:0], fits};
            done_next  = (count_reg == CW'(1));
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hdl/short_cycle_lockout_guard.sv
// Short-cycle lockout guard: one control tick in, one lockout status beat out.
//
// demand channel: one beat per control tick carrying demand_on.
// result channel: one beat per tick with locked_out, tripped and
//   lockout_ticks_left as they stand after that tick.
// cfg port: write enable, index and data; take effect at the edge, write only
//   while no tick is in flight.
// Sequence: a tick with a running lockout or no on-to-off edge goes straight
//   to the done state, which loads its result into the output register. An
//   on-to-off edge walks every stop-time memory entry (one RAM read, a load
//   state and a bit-serial divide for the age in minutes), then writes back
//   the stop time and presents the result.
// One tick is in work at a time; the next tick can be taken once its result
//   is in the output register, even if the receiver has not taken it yet.
//   A stalled receiver holds the sequencer only when a second result is ready.
// Reset: configuration returns to its defaults, the tick counter, lockout and
//   remembered demand clear, and every stop-time entry reads as the reset
//   stamp through per-entry valid bits; no clearing pass is needed.
`include "short_cycle_lockout_guard_defines.svh"

module short_cycle_lockout_guard #(
    parameter int STOP_HISTORY = scslg_pkg::STOP_HISTORY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // demand channel
    input  logic                             demand_valid,
    output logic                             demand_ready,
    input  logic                             demand_on,
    // result channel
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             locked_out,
    output logic                             tripped,
    output logic [scslg_pkg::LOCK_W-1:0]     lockout_ticks_left,
    // configuration
    input  logic                             cfg_write_en,
    input  logic [scslg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scslg_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int TW    = scslg_pkg::TIME_W;
    localparam int MW    = scslg_pkg::MIN_W;
    localparam int LW    = scslg_pkg::LIM_W;
    localparam int KW    = scslg_pkg::LOCK_W;
    localparam int PW    = scslg_pkg::TPM_W;
    localparam int IDX_W = $clog2(STOP_HISTORY);
    localparam int CNT_W = $clog2(STOP_HISTORY + 1);

    // Configuration registers
    logic [PW-1:0] tpm_reg;
    logic [MW-1:0] small_win_reg;
    logic [MW-1:0] large_win_reg;
    logic [LW-1:0] small_lim_reg;
    logic [LW-1:0] large_lim_reg;
    logic [MW-1:0] recovery_reg;

    // Control state
    scslg_pkg::state_t  state_reg, state_next;
    logic [TW-1:0]           tick_reg;
    logic [KW-1:0]           lockout_reg;
    logic                    prev_on_reg;
    logic [STOP_HISTORY-1:0] valid_reg;
    logic                    result_valid_reg;

    // Per-tick working registers
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] small_cnt_reg;
    logic [CNT_W-1:0] large_cnt_reg;
    logic [TW-1:0]    oldest_reg;
    logic [IDX_W-1:0] victim_reg;
    logic             trip_reg;
    logic             locked_out_reg;
    logic             tripped_reg;
    logic [KW-1:0]    left_reg;

    // Handshake and strobes
    logic accept;
    logic result_load;
    logic ram_rd_en;
    logic ram_wr_en;
    logic div_start;
    logic last_entry;

    logic [TW-1:0] ram_rd_data;
    logic [TW-1:0] stamp;
    logic          over_limit;
    logic [KW-1:0] load_ticks;

    scslg_pkg::div_req_t div_req;
    scslg_pkg::div_rsp_t div_rsp;

    // Stop-time history
    scslg_ram #(
        .WIDTH (TW),
        .DEPTH (STOP_HISTORY)
    ) u_stop_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (victim_reg),
        .wr_data (tick_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Age in minutes
    scslg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept      = demand_valid && demand_ready;
    assign last_entry  = (idx_reg == IDX_W'(STOP_HISTORY - 1));
    assign stamp       = valid_reg[idx_reg] ? ram_rd_data : scslg_pkg::STOP_RESET_VALUE;

    assign div_req = '{start: div_start, dividend: tick_reg - stamp, divisor: tpm_reg};

    // Trip decision and lockout length
    assign over_limit = ({{LW{1'b0}}, small_cnt_reg} > {{CNT_W{1'b0}}, small_lim_reg}) ||
                        ({{LW{1'b0}}, large_cnt_reg} > {{CNT_W{1'b0}}, large_lim_reg});
    assign load_ticks = {{(KW-MW){1'b0}}, recovery_reg} * {{(KW-PW){1'b0}}, tpm_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scslg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (lockout_reg == '0 && prev_on_reg && !demand_on)
                    begin
                        state_next = scslg_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = scslg_pkg::ST_DONE;
                    end
                end
            end
            scslg_pkg::ST_READ:  state_next = scslg_pkg::ST_LOAD;
            scslg_pkg::ST_LOAD:  state_next = scslg_pkg::ST_DIV;
            scslg_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = last_entry ? scslg_pkg::ST_WRITE : scslg_pkg::ST_READ;
                end
            end
            scslg_pkg::ST_WRITE: state_next = scslg_pkg::ST_DONE;
            scslg_pkg::ST_DONE:
            begin
                if (result_load)
                begin
                    state_next = scslg_pkg::ST_IDLE;
                end
            end
            default:             state_next = scslg_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        demand_ready  = 1'b0;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;
        div_start     = 1'b0;
        result_load   = 1'b0;
        case (state_reg)
            scslg_pkg::ST_IDLE:  demand_ready  = 1'b1;
            scslg_pkg::ST_READ:  ram_rd_en     = 1'b1;
            scslg_pkg::ST_LOAD:  div_start     = 1'b1;
            scslg_pkg::ST_WRITE: ram_wr_en     = 1'b1;
            scslg_pkg::ST_DONE:  result_load   = !result_valid_reg || result_ready;
            default:             demand_ready  = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= scslg_pkg::ST_IDLE;
            tick_reg         <= '0;
            lockout_reg      <= '0;
            prev_on_reg      <= 1'b0;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
            tpm_reg          <= scslg_pkg::TPM_RESET;
            small_win_reg    <= scslg_pkg::SMALL_WIN_RESET;
            large_win_reg    <= scslg_pkg::LARGE_WIN_RESET;
            small_lim_reg    <= scslg_pkg::SMALL_LIM_RESET;
            large_lim_reg    <= scslg_pkg::LARGE_LIM_RESET;
            recovery_reg     <= scslg_pkg::RECOVERY_RESET;
        end
        else
        begin
            state_reg <= state_next;

            // Tick counter, lockout countdown, remembered demand
            if (accept)
            begin
                tick_reg <= tick_reg + TW'(1);
                if (lockout_reg != '0)
                begin
                    lockout_reg <= lockout_reg - KW'(1);
                end
                else
                begin
                    prev_on_reg <= demand_on;
                end
            end

            // Write back the stop time and load a lockout on a trip
            if (ram_wr_en)
            begin
                valid_reg[victim_reg] <= 1'b1;
                if (over_limit)
                begin
                    lockout_reg <= load_ticks;
                end
            end

            // Output register valid
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            // Configuration writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    scslg_pkg::CFG_TICKS_PER_MINUTE:     tpm_reg       <= cfg_data;
                    scslg_pkg::CFG_SMALL_WINDOW_MINUTES: small_win_reg <= cfg_data[MW-1:0];
                    scslg_pkg::CFG_LARGE_WINDOW_MINUTES: large_win_reg <= cfg_data[MW-1:0];
                    scslg_pkg::CFG_SMALL_COUNT_LIMIT:    small_lim_reg <= cfg_data[LW-1:0];
                    scslg_pkg::CFG_LARGE_COUNT_LIMIT:    large_lim_reg <= cfg_data[LW-1:0];
                    scslg_pkg::CFG_RECOVERY_MINUTES:     recovery_reg  <= cfg_data[MW-1:0];
                    default:                             tpm_reg       <= tpm_reg;
                endcase
            end
        end
    end

    // Scan datapath and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg       <= '0;
            small_cnt_reg <= '0;
            large_cnt_reg <= '0;
            trip_reg      <= 1'b0;
        end

        // Fold one age into the window counts and the oldest-entry search
        if (state_reg == scslg_pkg::ST_DIV && div_rsp.done)
        begin
            if (div_rsp.quotient <= {{(TW-MW){1'b0}}, small_win_reg})
            begin
                small_cnt_reg <= small_cnt_reg + CNT_W'(1);
            end
            if (div_rsp.quotient <= {{(TW-MW){1'b0}}, large_win_reg})
            begin
                large_cnt_reg <= large_cnt_reg + CNT_W'(1);
            end
            if (idx_reg == '0 || div_rsp.quotient > oldest_reg)
            begin
                oldest_reg <= div_rsp.quotient;
                victim_reg <= idx_reg;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end

        if (ram_wr_en)
        begin
            trip_reg <= over_limit && (load_ticks != '0);
        end

        if (result_load)
        begin
            locked_out_reg <= (lockout_reg != '0);
            tripped_reg    <= trip_reg;
            left_reg       <= lockout_reg;
        end
    end

    assign result_valid       = result_valid_reg;
    assign locked_out         = locked_out_reg;
    assign tripped            = tripped_reg;
    assign lockout_ticks_left = left_reg;

    // Checks
    `SCSLG_ASSERT_NOW(a_trip_locks, result_valid && tripped, locked_out, "trip without lockout")
    `SCSLG_ASSERT_NOW(a_locked_matches, result_valid, locked_out == (lockout_ticks_left != '0), "bad locked_out")
    `SCSLG_ASSERT_NEXT(a_lockout_skips_scan, accept && lockout_reg != '0, state_reg == scslg_pkg::ST_DONE, "scan in lockout")
    `SCSLG_ASSERT_NOW(a_div_done_in_scan, div_rsp.done, state_reg == scslg_pkg::ST_DIV, "divider done outside scan")

endmodule

FILE: tb/tb_short_cycle_lockout_guard.sv
// Self-checking testbench for the short-cycle lockout guard: scoreboard model plus drivers.
module tb_short_cycle_lockout_guard;

    localparam int HIST        = scslg_pkg::STOP_HISTORY;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 300;

    localparam int TIME_W     = scslg_pkg::TIME_W;
    localparam int TPM_W      = scslg_pkg::TPM_W;
    localparam int MIN_W      = scslg_pkg::MIN_W;
    localparam int LIM_W      = scslg_pkg::LIM_W;
    localparam int LOCK_W     = scslg_pkg::LOCK_W;
    localparam int CFG_IDX_W  = scslg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = scslg_pkg::CFG_DATA_W;

    // One full register set
    typedef struct {
        logic [TPM_W-1:0] tpm;
        logic [MIN_W-1:0] small_win;
        logic [MIN_W-1:0] large_win;
        logic [LIM_W-1:0] small_lim;
        logic [LIM_W-1:0] large_lim;
        logic [MIN_W-1:0] recovery;
    } guard_cfg_t;

    // One expected status beat
    typedef struct {
        logic              locked;
        logic              tripped;
        logic [LOCK_W-1:0] left;
    } guard_beat_t;

    // Scoreboard: mirrors the guard state and holds the expected status beats
    class lockout_scoreboard;
        guard_cfg_t        cfg;
        logic [TIME_W-1:0] now_tick;
        logic [TIME_W-1:0] stop_stamps [HIST];
        logic              prev_on;
        logic [LOCK_W-1:0] lock_left;
        guard_beat_t       expected_beats [$];
        int                errors;

        function new();
            cfg.tpm       = scslg_pkg::TPM_RESET;
            cfg.small_win = scslg_pkg::SMALL_WIN_RESET;
            cfg.large_win = scslg_pkg::LARGE_WIN_RESET;
            cfg.small_lim = scslg_pkg::SMALL_LIM_RESET;
            cfg.large_lim = scslg_pkg::LARGE_LIM_RESET;
            cfg.recovery  = scslg_pkg::RECOVERY_RESET;
            now_tick  = '0;
            prev_on   = 1'b0;
            lock_left = '0;
            errors    = 0;
            foreach (stop_stamps[k])
                stop_stamps[k] = scslg_pkg::STOP_RESET_VALUE;
        endfunction

        function void set_config(guard_cfg_t c);
            cfg = c;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Whole minutes since a stop; a zero divisor reads as all ones
        function logic [TIME_W-1:0] age_minutes(logic [TIME_W-1:0] stamp);
            logic [TIME_W-1:0] diff;
            diff = now_tick - stamp;
            if (cfg.tpm == '0)
                return '1;
            return diff / TIME_W'(cfg.tpm);
        endfunction

        // Advance the mirror by one accepted tick and queue its status
        function void note_tick(logic on);
            guard_beat_t       beat;
            int unsigned       small_cnt;
            int unsigned       large_cnt;
            int unsigned       victim;
            logic [TIME_W-1:0] age;
            logic [TIME_W-1:0] oldest;
            logic [TIME_W-1:0] load;
            beat.tripped = 1'b0;
            now_tick = now_tick + 1;
            if (lock_left != '0)
            begin
                lock_left = lock_left - 1'b1;
            end
            else
            begin
                if (prev_on && !on)
                begin
                    small_cnt = 0;
                    large_cnt = 0;
                    victim    = 0;
                    oldest    = age_minutes(stop_stamps[0]);
                    for (int k = 0; k < HIST; k++)
                    begin
                        age = age_minutes(stop_stamps[k]);
                        if (age <= TIME_W'(cfg.small_win))
                            small_cnt++;
                        if (age <= TIME_W'(cfg.large_win))
                            large_cnt++;
                        if (age > oldest)
                        begin
                            oldest = age;
                            victim = k;
                        end
                    end
                    if (small_cnt > cfg.small_lim || large_cnt > cfg.large_lim)
                    begin
                        load = TIME_W'(cfg.recovery) * TIME_W'(cfg.tpm);
                        lock_left    = load[LOCK_W-1:0];
                        beat.tripped = (load[LOCK_W-1:0] != '0);
                    end
                    stop_stamps[victim] = now_tick;
                end
                prev_on = on;
            end
            beat.locked = (lock_left != '0);
            beat.left   = lock_left;
            expected_beats.push_back(beat);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        // Compare one taken status beat against the oldest expectation
        task check_beat(logic locked, logic trip, logic [LOCK_W-1:0] left);
            guard_beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                report("status beat with nothing expected");
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                if (locked !== exp_beat.locked)
                    report($sformatf("locked_out got %b want %b", locked, exp_beat.locked));
                if (trip !== exp_beat.tripped)
                    report($sformatf("tripped got %b want %b", trip, exp_beat.tripped));
                if (left !== exp_beat.left)
                    report($sformatf("lockout_ticks_left got %0d want %0d",
                                     left, exp_beat.left));
            end
        endtask
    endclass

    // Block ports
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              demand_valid = 1'b0;
    logic              demand_ready;
    logic              demand_on    = 1'b0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              locked_out;
    logic              tripped;
    logic [LOCK_W-1:0] lockout_ticks_left;
    logic              cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lockout_scoreboard sb = new();

    // Idling controls shared by the drivers
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int cycles       = 0;

    short_cycle_lockout_guard i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .demand_valid       (demand_valid),
        .demand_ready       (demand_ready),
        .demand_on          (demand_on),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .locked_out         (locked_out),
        .tripped            (tripped),
        .lockout_ticks_left (lockout_ticks_left),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_short_cycle_lockout_guard: FAIL");
        $finish;
    end

    // Status receiver: check taken beats, drive ready with stalls and hold-offs
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_beat(locked_out, tripped, lockout_ticks_left);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Send one tick beat; returns at the edge that takes it
    task send_tick(logic on);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct)
            gap++;
        if (gap > 0)
        begin
            demand_valid <= 1'b0;
            demand_on    <= 1'($urandom_range(1));
            repeat (gap) @(posedge clk);
        end
        demand_valid <= 1'b1;
        demand_on    <= on;
        do
            @(posedge clk);
        while (!demand_ready);
        sb.note_tick(on);
    endtask

    // Wait until every expected status beat has been taken
    task wait_drained();
        demand_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write the full register set while the guard is idle
    task write_settings(guard_cfg_t c);
        cfg_write_en <= 1'b1;
        cfg_index    <= scslg_pkg::CFG_TICKS_PER_MINUTE;
        cfg_data     <= CFG_DATA_W'(c.tpm);
        @(posedge clk);
        cfg_index    <= scslg_pkg::CFG_SMALL_WINDOW_MINUTES;
        cfg_data     <= CFG_DATA_W'(c.small_win);
        @(posedge clk);
        cfg_index    <= scslg_pkg::CFG_LARGE_WINDOW_MINUTES;
        cfg_data     <= CFG_DATA_W'(c.large_win);
        @(posedge clk);
        cfg_index    <= scslg_pkg::CFG_SMALL_COUNT_LIMIT;
        cfg_data     <= CFG_DATA_W'(c.small_lim);
        @(posedge clk);
        cfg_index    <= scslg_pkg::CFG_LARGE_COUNT_LIMIT;
        cfg_data     <= CFG_DATA_W'(c.large_lim);
        @(posedge clk);
        cfg_index    <= scslg_pkg::CFG_RECOVERY_MINUTES;
        cfg_data     <= CFG_DATA_W'(c.recovery);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_config(c);
    endtask

    // Mostly short minutes so the windows and lockouts stay reachable
    function guard_cfg_t random_settings();
        guard_cfg_t c;
        int         pick;
        pick = $urandom_range(9);
        if (pick <= 6)
            c.tpm = TPM_W'($urandom_range(1, 4));
        else if (pick == 7)
            c.tpm = '0;
        else if (pick == 8)
            c.tpm = TPM_W'($urandom_range(5, 200));
        else
            c.tpm = '1;
        c.small_win = ($urandom_range(9) == 0) ? MIN_W'($urandom_range(1023))
                                               : MIN_W'($urandom_range(0, 30));
        c.large_win = ($urandom_range(9) == 0) ? MIN_W'($urandom_range(1023))
                                               : MIN_W'($urandom_range(0, 60));
        c.small_lim = LIM_W'($urandom_range(0, 8));
        c.large_lim = LIM_W'($urandom_range(0, 8));
        if (c.tpm == '0)
            c.recovery = MIN_W'($urandom_range(1023));
        else if (c.tpm <= 4)
            c.recovery = MIN_W'($urandom_range(0, 8));
        else
            c.recovery = '0;
        return c;
    endfunction

    // On/off runs with random lengths, plus some noise ticks
    task run_random(int n);
        int sent;
        int run;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_tick(1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                run = $urandom_range(1, 3);
                repeat (run) send_tick(1'b1);
                sent += run;
                run = $urandom_range(1, 3);
                repeat (run) send_tick(1'b0);
                sent += run;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        guard_cfg_t c;
        logic       d1_ticks [14];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: reset stamps are far outside every window
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();

        // Small-window trip on the fourth quick stop, then a short lockout
        c.tpm = 16'd1; c.small_win = 10'd10; c.large_win = 10'd60;
        c.small_lim = 4'd2; c.large_lim = 4'd4; c.recovery = 10'd3;
        write_settings(c);
        d1_ticks = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 1, 1, 0, 1, 0};
        foreach (d1_ticks[k])
            send_tick(d1_ticks[k]);
        wait_drained();

        // Zero ticks per minute: ages all ones, nothing counts, no load
        c.tpm = '0; c.small_lim = '0; c.large_lim = '0; c.recovery = '1;
        write_settings(c);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();

        // Trip with zero length: count exceeds its limit, recovery is zero
        c.tpm = 16'd1; c.small_win = '1; c.large_win = '1; c.recovery = '0;
        write_settings(c);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();

        // Random phases across every idling style
        for (int phase = 0; phase < 8; phase++)
        begin
            write_settings(random_settings());
            case (phase % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 55;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 55;
                end
                default:
                begin
                    send_gap_pct = 38;
                    stall_pct    = 38;
                end
            endcase
            // Long receiver hold-off while ticks keep coming
            if (phase == 4)
                hold_left = 1500;
            run_random(48);
            wait_drained();
        end

        // Extremes: widest minute, zero and full windows, longest lockout
        send_gap_pct = 0;
        stall_pct    = 0;
        c.tpm = '1; c.small_win = '0; c.large_win = '1;
        c.small_lim = '0; c.large_lim = 4'd8; c.recovery = '1;
        write_settings(c);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (6) send_tick(1'($urandom_range(1)));
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d status beats never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb_short_cycle_lockout_guard: PASS");
        else
            $display("tb_short_cycle_lockout_guard: FAIL");
        $finish;
    end

endmodule
